### hw/rtl/rtzl_pkg.sv
// ----------------------------------------------------------------------------
// rtzl_pkg
// Shared types and constants of the ray/triangle zone lookup.
// ----------------------------------------------------------------------------
package rtzl_pkg;

  localparam int unsigned ZoneCountDef = 256;
  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned ZoneW        = 8;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned MulSteps     = 6;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_TRI   = 1'b1
  } op_e;

  typedef struct packed {
    op_e  op;
    logic zone_ok;
    logic last;
  } ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_CHECK,
    S_TERM,
    S_DIVINIT,
    S_DIV,
    S_UPD,
    S_EMIT
  } state_e;

endpackage

### hw/rtl/axis_ray_triangle_zone_lookup_core.sv
// ----------------------------------------------------------------------------
// axis_ray_triangle_zone_lookup_core
// Zone lookup by casting a +x ray from a point through a triangle stream.
// ----------------------------------------------------------------------------
// Input stream: a query word (tuser = 0) sets the point and clears the best
// hit; triangle words (tuser = 1) follow, and the one with tlast set yields
// one output word with the nearest zone, its hit x and a hit flag (tuser).
// cfg_we_i writes the zone reported when no triangle is hit.
// A two-word queue sits between the input side and the execution side, so
// the input keeps taking words while a triangle is being worked on.
// A query is handled in S_IDLE as it is popped from the queue. A triangle
// goes through edge products (S_EDGE), a reject check (S_CHECK) and
// distance products (S_TERM) on one shared multiplier, a restoring divide
// (S_DIVINIT, S_DIV) and the best-hit update (S_UPD); rejected triangles
// leave early. A triangle with tlast then loads the output register in S_EMIT.
// Reset clears the queue, the point, the best hit and the output valid.
// When the receiver stalls, the output word holds, the execution side waits
// and the queue fills, then tready drops.
// ----------------------------------------------------------------------------
module axis_ray_triangle_zone_lookup_core import rtzl_pkg::*; #(
  parameter int unsigned NUM_ZONES  = ZoneCountDef,
  parameter int unsigned COORD_BITS = CoordBitsDef,
  localparam int unsigned CrdW      = 9 * COORD_BITS,
  localparam int unsigned InDataW   = ((CrdW + ZoneW + 7) / 8) * 8,
  localparam int unsigned OutDataW  = ((ZoneW + COORD_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ZoneW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // x0, y0, z0, x1, y1, z1, x2, y2, z2, zone
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // operation
  input  logic                s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // found_zone, hit_coord
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // hit_found
  output logic                m_axis_tuser_o
);

  logic             q_valid, q_pop;
  ctl_t             q_ctl;
  logic [CrdW-1:0]  q_crd;
  logic [ZoneW-1:0] q_zone;
  logic [ZoneW-1:0] outside_zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_zone_q <= '0;
    end else if (cfg_we_i) begin
      outside_zone_q <= cfg_wdata_i;
    end
  end

  rtzl_front #(
    .NUM_ZONES  (NUM_ZONES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_ctl_o    (q_ctl),
    .q_crd_o    (q_crd),
    .q_zone_o   (q_zone)
  );

  rtzl_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_ctl_i        (q_ctl),
    .q_crd_i        (q_crd),
    .q_zone_i       (q_zone),
    .outside_zone_i (outside_zone_q),
    .m_tvalid_o     (m_axis_tvalid_o),
    .m_tready_i     (m_axis_tready_i),
    .m_tdata_o      (m_axis_tdata_o),
    .m_tuser_o      (m_axis_tuser_o)
  );

endmodule

### hw/rtl/rtzl_front.sv
// ----------------------------------------------------------------------------
// rtzl_front
// Input side: takes words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rtzl_front import rtzl_pkg::*; #(
  parameter int unsigned NUM_ZONES   = ZoneCountDef,
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  localparam int unsigned CrdW       = 9 * COORD_BITS,
  localparam int unsigned InDataW    = ((CrdW + ZoneW + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [InDataW-1:0] s_tdata_i,
  input  logic               s_tuser_i,
  input  logic               s_tlast_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output ctl_t               q_ctl_o,
  output logic [CrdW-1:0]    q_crd_o,
  output logic [ZoneW-1:0]   q_zone_o
);

  localparam int unsigned QAW = $clog2(QueueDepth);

  ctl_t                 ctl_q  [QueueDepth];
  logic [CrdW-1:0]      crd_q  [QueueDepth];
  logic [ZoneW-1:0]     zone_q [QueueDepth];
  logic [QAW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QAW:0]         cnt_q, cnt_d;
  logic                 push, pop;
  ctl_t                 ctl_in;
  logic [ZoneW-1:0]     zone_in;

  assign zone_in        = s_tdata_i[CrdW +: ZoneW];
  assign ctl_in.op      = op_e'(s_tuser_i);
  assign ctl_in.zone_ok = (32'(zone_in) < 32'(NUM_ZONES));
  assign ctl_in.last    = s_tlast_i;

  assign s_tready_o = (cnt_q != (QAW+1)'(QueueDepth));
  assign push       = s_tvalid_i & s_tready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i & q_valid_o;

  assign q_ctl_o  = ctl_q[rd_ptr_q];
  assign q_crd_o  = crd_q[rd_ptr_q];
  assign q_zone_o = zone_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q]  <= ctl_in;
      crd_q[wr_ptr_q]  <= s_tdata_i[CrdW-1:0];
      zone_q[wr_ptr_q] <= zone_in;
    end
  end

endmodule

### hw/rtl/rtzl_back.sv
// ----------------------------------------------------------------------------
// rtzl_back
// Execution side: edge terms, hit distance divide, running nearest hit.
// ----------------------------------------------------------------------------
module rtzl_back import rtzl_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  localparam int unsigned CrdW      = 9 * COORD_BITS,
  localparam int unsigned OutDataW  = ((ZoneW + COORD_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  ctl_t                q_ctl_i,
  input  logic [CrdW-1:0]     q_crd_i,
  input  logic [ZoneW-1:0]    q_zone_i,
  input  logic [ZoneW-1:0]    outside_zone_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic                m_tuser_o
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DF  = CB + 1;
  localparam int unsigned AW  = CB + 2;
  localparam int unsigned EW  = 2 * CB + 3;
  localparam int unsigned L   = CB + 1;
  localparam int unsigned TW  = 3 * CB + 4;
  localparam int unsigned QB  = CB + 1;
  localparam int unsigned DCW = $clog2(CB + 1);
  localparam logic signed [CB-1:0] CMax = {1'b0, {(CB-1){1'b1}}};

  state_e state_q, state_d;

  logic signed [CB-1:0]   px_q, py_q, pz_q, best_hit_q;
  logic [ZoneW-1:0]       best_zone_q, zone_q;
  logic                   any_hit_q, last_q, hit_ok_q;
  logic signed [DF-1:0]   d_q [9];
  logic signed [EW-1:0]   u_q, v_q, w_q;
  logic [EW-1:0]          det_q, det_sum;
  logic signed [TW-1:0]   t_q;
  logic [TW-1:0]          rem_q, dsh_q;
  logic [QB-1:0]          quo_q;
  logic [DCW-1:0]         dcnt_q;
  logic [2:0]             cnt_q, pidx_q;
  logic                   pv_q;
  logic signed [AW-1:0]   mul_a;
  logic signed [DF-1:0]   mul_b;
  logic signed [EW-1:0]   prod_q;
  logic signed [TW-1:0]   prod_ext;
  logic signed [CB+1:0]   hit_full;
  logic signed [CB-1:0]   hit_c;
  logic                   reject, do_issue, out_load, better;
  logic                   out_valid_q;
  logic [ZoneW-1:0]       out_zone_q;
  logic signed [CB-1:0]   out_hit_q;
  logic                   out_found_q;

  // diff index: a = 0..2, b = 3..5, c = 6..8 (x, y, z)
  function automatic logic signed [AW-1:0] sx(input logic signed [DF-1:0] d);
    sx = {d[DF-1], d};
  endfunction

  assign det_sum  = {1'b0, u_q[EW-2:0]} + {1'b0, v_q[EW-2:0]} + {1'b0, w_q[EW-2:0]};
  assign reject   = u_q[EW-1] | v_q[EW-1] | w_q[EW-1] | (det_sum == '0);
  assign do_issue = ((state_q == S_EDGE) || (state_q == S_TERM)) &&
                    (cnt_q < 3'(MulSteps));
  assign out_load = !out_valid_q || m_tready_i;
  assign prod_ext = TW'(prod_q);

  assign hit_full = (CB+2)'(px_q) + $signed({1'b0, quo_q});
  assign hit_c    = (hit_full > (CB+2)'(CMax)) ? CMax : hit_full[CB-1:0];
  assign better   = hit_ok_q && (!any_hit_q || (hit_c < best_hit_q));

  always_comb begin
    mul_a = sx(d_q[7]);
    mul_b = d_q[5];
    if (state_q == S_EDGE) begin
      case (cnt_q)
        3'd0:    begin mul_a = sx(d_q[7]); mul_b = d_q[5]; end
        3'd1:    begin mul_a = sx(d_q[8]); mul_b = d_q[4]; end
        3'd2:    begin mul_a = sx(d_q[1]); mul_b = d_q[8]; end
        3'd3:    begin mul_a = sx(d_q[2]); mul_b = d_q[7]; end
        3'd4:    begin mul_a = sx(d_q[4]); mul_b = d_q[2]; end
        default: begin mul_a = sx(d_q[5]); mul_b = d_q[1]; end
      endcase
    end else begin
      case (cnt_q)
        3'd0:    begin mul_a = {1'b0, u_q[L-1:0]};    mul_b = d_q[0]; end
        3'd1:    begin mul_a = {1'b0, u_q[EW-2:L]};   mul_b = d_q[0]; end
        3'd2:    begin mul_a = {1'b0, v_q[L-1:0]};    mul_b = d_q[3]; end
        3'd3:    begin mul_a = {1'b0, v_q[EW-2:L]};   mul_b = d_q[3]; end
        3'd4:    begin mul_a = {1'b0, w_q[L-1:0]};    mul_b = d_q[6]; end
        default: begin mul_a = {1'b0, w_q[EW-2:L]};   mul_b = d_q[6]; end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && (q_ctl_i.op == OP_TRI)) begin
          state_d = q_ctl_i.zone_ok ? S_EDGE : S_UPD;
        end
      end
      S_EDGE:    if (cnt_q == 3'(MulSteps)) state_d = S_CHECK;
      S_CHECK:   state_d = reject ? S_UPD : S_TERM;
      S_TERM:    if (cnt_q == 3'(MulSteps)) state_d = S_DIVINIT;
      S_DIVINIT: state_d = t_q[TW-1] ? S_UPD : S_DIV;
      S_DIV:     if (dcnt_q == '0) state_d = S_UPD;
      S_UPD:     state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    q_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE:  q_pop_o = q_valid_i;
      default: q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      best_hit_q  <= CMax;
      best_zone_q <= '0;
      any_hit_q   <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= do_issue;
      if ((state_q == S_IDLE) && q_valid_i && (q_ctl_i.op == OP_QUERY)) begin
        px_q        <= q_crd_i[0*CB +: CB];
        py_q        <= q_crd_i[1*CB +: CB];
        pz_q        <= q_crd_i[2*CB +: CB];
        best_hit_q  <= CMax;
        best_zone_q <= '0;
        any_hit_q   <= 1'b0;
      end
      if ((state_q == S_UPD) && better) begin
        best_hit_q  <= hit_c;
        best_zone_q <= zone_q;
        any_hit_q   <= 1'b1;
      end
      if (state_q == S_EMIT && out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_issue) begin
      prod_q <= EW'(mul_a * mul_b);
      pidx_q <= cnt_q;
    end
    unique case (state_q)
      S_IDLE: begin
        cnt_q    <= '0;
        u_q      <= '0;
        v_q      <= '0;
        w_q      <= '0;
        hit_ok_q <= 1'b0;
        zone_q   <= q_zone_i;
        last_q   <= q_ctl_i.last;
        for (int i = 0; i < 9; i++) begin
          d_q[i] <= $signed({q_crd_i[i*CB+CB-1], q_crd_i[i*CB +: CB]}) -
                    ((i % 3 == 0) ? DF'(px_q) : (i % 3 == 1) ? DF'(py_q) : DF'(pz_q));
        end
      end
      S_EDGE: begin
        cnt_q <= cnt_q + 3'd1;
        if (pv_q) begin
          case (pidx_q)
            3'd0:    u_q <= u_q + prod_q;
            3'd1:    u_q <= u_q - prod_q;
            3'd2:    v_q <= v_q + prod_q;
            3'd3:    v_q <= v_q - prod_q;
            3'd4:    w_q <= w_q + prod_q;
            default: w_q <= w_q - prod_q;
          endcase
        end
      end
      S_CHECK: begin
        det_q <= det_sum;
        t_q   <= '0;
        cnt_q <= '0;
      end
      S_TERM: begin
        cnt_q <= cnt_q + 3'd1;
        if (pv_q) begin
          t_q <= t_q + (pidx_q[0] ? (prod_ext <<< L) : prod_ext);
        end
      end
      S_DIVINIT: begin
        rem_q    <= t_q;
        dsh_q    <= TW'(det_q) << CB;
        quo_q    <= '0;
        dcnt_q   <= DCW'(CB);
        hit_ok_q <= ~t_q[TW-1];
      end
      S_DIV: begin
        dcnt_q <= dcnt_q - 1'b1;
        dsh_q  <= dsh_q >> 1;
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[QB-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[QB-2:0], 1'b0};
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
    if (state_q == S_EMIT && out_load) begin
      out_zone_q  <= any_hit_q ? best_zone_q : outside_zone_i;
      out_hit_q   <= best_hit_q;
      out_found_q <= any_hit_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OutDataW'({out_hit_q, out_zone_q});
  assign m_tuser_o  = out_found_q;

endmodule

### hw/rtl/rtzl_checker.sv
// ----------------------------------------------------------------------------
// rtzl_checker
// Port-level checks of the zone lookup core, bound to the top level.
// ----------------------------------------------------------------------------
module rtzl_checker import rtzl_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  localparam int unsigned OutDataW  = ((ZoneW + COORD_BITS + 7) / 8) * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tuser_o
);

  localparam logic [COORD_BITS-1:0] CMax = {1'b0, {(COORD_BITS-1){1'b1}}};

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_miss_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[ZoneW +: COORD_BITS] == CMax)
    else $error("miss word without maximum coordinate");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind axis_ray_triangle_zone_lookup_core rtzl_checker #(
  .COORD_BITS (COORD_BITS)
) u_rtzl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
